/* hdl/lvi_pkg.sv */
// Shared types and constants for the layered velocity interpolation block.
// Used by the table memory, the shared divider and the top-level sequencer.
// No dependencies.
package lvi_pkg;

    localparam int MAX_LAYERS = 64;
    localparam int LAYER_AW   = $clog2(MAX_LAYERS);
    // Wide enough to hold the bounds of the search, 0 .. MAX_LAYERS.
    localparam int BOUND_W    = $clog2(MAX_LAYERS + 1);

    localparam int CFG_W    = 7;
    localparam int FUNC_W   = 2;
    localparam int RADIUS_W = 23;
    localparam int VEL_W    = 24;
    localparam int SPEED_W  = 25;

    // Interpolation datapath widths.
    localparam int DR_W   = RADIUS_W + 1;
    localparam int DV_W   = VEL_W + 1;
    localparam int PROD_W = DR_W + DV_W;
    localparam int DVD_W  = PROD_W - 2;
    localparam int DVS_W  = RADIUS_W;
    localparam int DIV_CW = $clog2(DVD_W + 1);

    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY_P = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY_S = 2'd2;

    localparam logic [CFG_W-1:0] LAYER_COUNT_RESET = 7'd2;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [VEL_W-1:0]    p_vel;
        logic [VEL_W-1:0]    s_vel;
    } lvi_entry_t;

    typedef struct packed {
        logic                en;
        logic [LAYER_AW-1:0] addr;
        lvi_entry_t          entry;
    } lvi_wr_t;

endpackage

/* hdl/lvi_table.sv */
// Layer table memory: one write port and one registered read port.
// Depends on lvi_pkg for the entry type and depth.
module lvi_table
    import lvi_pkg::*;
(
    input  logic                clk,
    input  lvi_wr_t             wr,
    input  logic [LAYER_AW-1:0] raddr,
    output lvi_entry_t          rdata
);

    lvi_entry_t mem [MAX_LAYERS];
    lvi_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/lvi_div.sv */
// Restoring divider for magnitudes, one quotient bit per cycle.
// Depends on lvi_pkg for the dividend and divisor widths.
module lvi_div
    import lvi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    shifted;
    logic [DVS_W+1:0]  trial;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The remainder stays below the divisor, so it fits in DVS_W bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DVS_W+1])
            begin
                rem_reg <= trial[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* hdl/layer_velocity_interpolation_core.sv */
// Layered velocity table with piecewise-linear lookup, top-level sequencer.
// A write request leaves the sequencer idle and ready for the next request. A query runs a
// binary search over the layer radii, reads the two knots, multiplies and divides; a
// zero-width interval skips the divider. A result still held at the output delays the latch,
// and the next request is taken once the sequencer is back in idle. Reset clears the sequencer and the
// output valid and sets layer_count to 2; table contents are undefined until written.
module layer_velocity_interpolation_core
    import lvi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [FUNC_W-1:0]         func,
    input  logic [LAYER_AW-1:0]       layer_index,
    input  logic [RADIUS_W-1:0]       radius_m,
    input  logic [VEL_W-1:0]          p_speed,
    input  logic [VEL_W-1:0]          s_speed,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SPEED_W-1:0] speed,
    output logic [LAYER_AW-1:0]       interval,
    output logic                      zero_width,
    output logic                      saturated
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_RD0      = 4'd3;
    localparam logic [3:0] S_RD1      = 4'd4;
    localparam logic [3:0] S_DIFF     = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_DIVGO    = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    localparam int VAL_W = PROD_W;

    logic [3:0]          state_reg, state_next;
    logic [CFG_W-1:0]    layer_count_reg;
    logic                out_valid_reg;

    logic                use_s_reg;
    logic [RADIUS_W-1:0] rad_reg;
    logic [BOUND_W-1:0]  lp_reg;     // lower search bound plus one
    logic [BOUND_W-1:0]  hi_reg;
    logic [LAYER_AW-1:0] mid_reg;
    logic [LAYER_AW-1:0] jl_reg;
    logic [RADIUS_W-1:0] r0_reg;
    logic [VEL_W-1:0]    v0_reg;
    logic signed [DR_W-1:0]   dr_reg;
    logic signed [DR_W-1:0]   den_reg;
    logic signed [DV_W-1:0]   dv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                zw_reg;
    logic                neg_reg;

    logic signed [SPEED_W-1:0] speed_reg;
    logic [LAYER_AW-1:0] interval_reg;
    logic                zero_width_reg;
    logic                saturated_reg;

    logic                accept;
    logic                query;
    logic [BOUND_W-1:0]  n_used;
    logic [BOUND_W:0]    mid_sum;
    logic [LAYER_AW-1:0] mid_calc;
    logic [BOUND_W-1:0]  lo_calc;
    logic [BOUND_W-1:0]  n_minus2;
    logic [BOUND_W-1:0]  jl_wide;
    logic [LAYER_AW-1:0] raddr;
    lvi_entry_t          rd_entry;
    logic [VEL_W-1:0]    rd_vel;
    lvi_wr_t             tbl_wr;

    logic                div_start;
    logic                div_done;
    logic [DVD_W-1:0]    div_quo;
    logic [PROD_W-1:0]   prod_abs;
    logic [DR_W-1:0]     den_abs;
    logic signed [VAL_W-1:0] quo_signed;
    logic signed [VAL_W-1:0] val_sum;
    logic                val_fits;
    logic                out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign query    = (func == FUNC_QUERY_P) || (func == FUNC_QUERY_S);
    assign out_free = !out_valid_reg || out_ready;

    // Every 6-bit index addresses the 64-entry table, so each write lands.
    assign tbl_wr.en           = accept && (func == FUNC_WRITE);
    assign tbl_wr.addr         = layer_index;
    assign tbl_wr.entry.radius = radius_m;
    assign tbl_wr.entry.p_vel  = p_speed;
    assign tbl_wr.entry.s_vel  = s_speed;

    always_comb
    begin
        if (layer_count_reg < CFG_W'(2))
        begin
            n_used = BOUND_W'(2);
        end
        else if (layer_count_reg > CFG_W'(MAX_LAYERS))
        begin
            n_used = BOUND_W'(MAX_LAYERS);
        end
        else
        begin
            n_used = BOUND_W'(layer_count_reg);
        end
    end

    // The sum of the bounds is never negative while the search runs.
    assign mid_sum  = {1'b0, hi_reg} + {1'b0, lp_reg} - 1'b1;
    assign mid_calc = mid_sum[LAYER_AW:1];

    assign lo_calc  = (lp_reg == '0) ? '0 : lp_reg - 1'b1;
    assign n_minus2 = n_used - BOUND_W'(2);
    assign jl_wide  = (lo_calc > n_minus2) ? n_minus2 : lo_calc;

    always_comb
    begin
        unique case (state_reg)
            S_SRCH_RD: raddr = mid_calc;
            S_RD0:     raddr = jl_reg;
            S_RD1:     raddr = jl_reg + 1'b1;
            default:   raddr = jl_reg;
        endcase
    end

    lvi_table u_table (
        .clk   (clk),
        .wr    (tbl_wr),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    assign rd_vel = use_s_reg ? rd_entry.s_vel : rd_entry.p_vel;

    assign prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign den_abs   = den_reg[DR_W-1] ? DR_W'(-den_reg) : DR_W'(den_reg);
    assign div_start = (state_reg == S_DIVGO);

    lvi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_abs[DVD_W-1:0]),
        .divisor  (den_abs[DVS_W-1:0]),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Truncation toward zero falls out of dividing magnitudes and fixing the sign.
    assign quo_signed = neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    assign val_sum    = $signed({{(VAL_W-VEL_W){1'b0}}, v0_reg}) + quo_signed;
    assign val_fits   = (val_sum[VAL_W-1:SPEED_W-1] == '0)
                     || (val_sum[VAL_W-1:SPEED_W-1] == '1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && query)
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                state_next = (hi_reg > lp_reg) ? S_SRCH_CMP : S_RD0;
            end
            S_SRCH_CMP: state_next = S_SRCH_RD;
            S_RD0:      state_next = S_RD1;
            S_RD1:      state_next = S_DIFF;
            S_DIFF:     state_next = S_MUL;
            S_MUL:      state_next = (den_reg == '0) ? S_DONE : S_DIVGO;
            S_DIVGO:    state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            layer_count_reg <= LAYER_COUNT_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                layer_count_reg <= cfg_wdata;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rad_reg   <= radius_m;
                    use_s_reg <= (func == FUNC_QUERY_S);
                    lp_reg    <= '0;
                    hi_reg    <= n_used;
                end
            end
            S_SRCH_RD:
            begin
                mid_reg <= mid_calc;
                jl_reg  <= jl_wide[LAYER_AW-1:0];
            end
            S_SRCH_CMP:
            begin
                if (rad_reg > rd_entry.radius)
                begin
                    lp_reg <= {1'b0, mid_reg} + 1'b1;
                end
                else
                begin
                    hi_reg <= {1'b0, mid_reg};
                end
            end
            S_RD1:
            begin
                r0_reg <= rd_entry.radius;
                v0_reg <= rd_vel;
            end
            S_DIFF:
            begin
                dr_reg  <= $signed({1'b0, rad_reg}) - $signed({1'b0, r0_reg});
                den_reg <= $signed({1'b0, rd_entry.radius}) - $signed({1'b0, r0_reg});
                dv_reg  <= $signed({1'b0, rd_vel}) - $signed({1'b0, v0_reg});
            end
            S_MUL:
            begin
                prod_reg <= dr_reg * dv_reg;
                zw_reg   <= (den_reg == '0);
            end
            S_DIVGO:
            begin
                neg_reg <= prod_reg[PROD_W-1] ^ den_reg[DR_W-1];
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    interval_reg   <= jl_reg;
                    zero_width_reg <= zw_reg;
                    if (zw_reg)
                    begin
                        speed_reg     <= $signed({1'b0, v0_reg});
                        saturated_reg <= 1'b0;
                    end
                    else if (val_fits)
                    begin
                        speed_reg     <= val_sum[SPEED_W-1:0];
                        saturated_reg <= 1'b0;
                    end
                    else
                    begin
                        speed_reg     <= val_sum[VAL_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}}
                                                          : {1'b0, {(SPEED_W-1){1'b1}}};
                        saturated_reg <= 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign speed      = speed_reg;
    assign interval   = interval_reg;
    assign zero_width = zero_width_reg;
    assign saturated  = saturated_reg;

endmodule

/* test/tb_layer_velocity_interpolation_core.sv */
// Self-checking testbench for layer_velocity_interpolation_core.
// Loads layered speed tables, queries P and S speeds under varied flow control and
// checks every result against a predictor built on lvi_pkg.
module tb_layer_velocity_interpolation_core;
    import lvi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int     RADIUS_MAX   = 2 ** RADIUS_W - 1;
    localparam int     VEL_MAX      = 2 ** VEL_W - 1;
    localparam longint SPEED_HI     = 2 ** (SPEED_W - 1) - 1;
    localparam longint SPEED_LO     = -(2 ** (SPEED_W - 1));
    localparam int     DRAIN_CYCLES = 100;
    localparam int     LIMIT_CYCLES = 1000000;
    localparam int     PHASES       = 8;
    localparam int     QUERY_ITEMS  = 20;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [LAYER_AW-1:0] layer_index;
        logic [RADIUS_W-1:0] radius;
        logic [VEL_W-1:0]    p_vel;
        logic [VEL_W-1:0]    s_vel;
    } tb_request_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [LAYER_AW-1:0]       interval;
        logic                      zero_width;
        logic                      saturated;
    } speed_result_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_we      = 1'b0;
    logic [CFG_W-1:0]          cfg_wdata   = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic [FUNC_W-1:0]         func        = FUNC_WRITE;
    logic [LAYER_AW-1:0]       layer_index = '0;
    logic [RADIUS_W-1:0]       radius_m    = '0;
    logic [VEL_W-1:0]          p_speed     = '0;
    logic [VEL_W-1:0]          s_speed     = '0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic signed [SPEED_W-1:0] speed;
    logic [LAYER_AW-1:0]       interval;
    logic                      zero_width;
    logic                      saturated;

    layer_velocity_interpolation_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .layer_index (layer_index),
        .radius_m    (radius_m),
        .p_speed     (p_speed),
        .s_speed     (s_speed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .speed       (speed),
        .interval    (interval),
        .zero_width  (zero_width),
        .saturated   (saturated)
    );

    tb_request_t   pending_requests[$];
    speed_result_t expected_speeds[$];

    // Predictor copy of the table and the layer count register.
    logic [RADIUS_W-1:0] tbl_radius [MAX_LAYERS];
    logic [VEL_W-1:0]    tbl_p      [MAX_LAYERS];
    logic [VEL_W-1:0]    tbl_s      [MAX_LAYERS];
    logic [CFG_W-1:0]    lyr_count;

    // Radii as the stimulus generator last wrote them, used to aim queries.
    logic [RADIUS_W-1:0] gen_radius [MAX_LAYERS];

    logic req_taken = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   fail_cnt       = 0;
    int   n_accepted     = 0;
    int   n_checked      = 0;
    int   cycle_cnt      = 0;
    int   layer_settings [PHASES] = '{127, 0, 64, 1, 3, 2, 40, 0};

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int clamp_layers(int v);
        if (v < 2)
            return 2;
        if (v > MAX_LAYERS)
            return MAX_LAYERS;
        return v;
    endfunction

    // Search, clamp and linear interpolation for one query.
    function automatic speed_result_t interp_speed(logic [FUNC_W-1:0] f,
                                                   logic [RADIUS_W-1:0] r);
        speed_result_t res;
        int     n;
        int     lo;
        int     hi;
        int     mid;
        longint r0;
        longint r1;
        longint v0;
        longint v1;
        longint num;
        longint den;
        longint val;
        n  = clamp_layers(int'(lyr_count));
        lo = -1;
        hi = n;
        while (hi - lo > 1)
        begin
            mid = (hi + lo) / 2;
            if (longint'(r) > longint'(tbl_radius[mid]))
                lo = mid;
            else
                hi = mid;
        end
        if (lo < 0)
            lo = 0;
        if (lo > n - 2)
            lo = n - 2;
        r0 = longint'(tbl_radius[lo]);
        r1 = longint'(tbl_radius[lo + 1]);
        v0 = (f == FUNC_QUERY_P) ? longint'(tbl_p[lo]) : longint'(tbl_s[lo]);
        v1 = (f == FUNC_QUERY_P) ? longint'(tbl_p[lo + 1]) : longint'(tbl_s[lo + 1]);
        den = r1 - r0;
        res.zero_width = 1'b0;
        res.saturated  = 1'b0;
        if (den == 0)
        begin
            val = v0;
            res.zero_width = 1'b1;
        end
        else
        begin
            num = (longint'(r) - r0) * (v1 - v0);
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            val = v0 + num / den;
            if (val > SPEED_HI)
            begin
                val = SPEED_HI;
                res.saturated = 1'b1;
            end
            else if (val < SPEED_LO)
            begin
                val = SPEED_LO;
                res.saturated = 1'b1;
            end
        end
        res.speed    = val[SPEED_W-1:0];
        res.interval = lo[LAYER_AW-1:0];
        return res;
    endfunction

    // Request side: track acceptance, mirror table and layer count writes and predict queries.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            lyr_count <= LAYER_COUNT_RESET;
        end
        else
        begin
            req_taken <= in_valid && in_ready;
            if (cfg_we)
                lyr_count <= cfg_wdata;
            if (in_valid && in_ready)
            begin
                n_accepted++;
                if (func == FUNC_WRITE)
                begin
                    tbl_radius[layer_index] <= radius_m;
                    tbl_p[layer_index]      <= p_speed;
                    tbl_s[layer_index]      <= s_speed;
                end
                else if (func == FUNC_QUERY_P || func == FUNC_QUERY_S)
                    expected_speeds.push_back(interp_speed(func, radius_m));
            end
        end
    end

    // Driver: a new request is presented only once the previous one was taken.
    always @(negedge clk)
    begin
        tb_request_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_requests.pop_front();
                in_valid    <= 1'b1;
                func        <= nxt.func;
                layer_index <= nxt.layer_index;
                radius_m    <= nxt.radius;
                p_speed     <= nxt.p_vel;
                s_speed     <= nxt.s_vel;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        speed_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_speeds.size() == 0)
            begin
                $error("unexpected result: speed %0d interval %0d", speed, interval);
                fail_cnt++;
            end
            else
            begin
                want = expected_speeds.pop_front();
                n_checked++;
                if (speed !== want.speed)
                begin
                    $error("speed: expected %0d, got %0d", want.speed, speed);
                    fail_cnt++;
                end
                if (interval !== want.interval)
                begin
                    $error("interval: expected %0d, got %0d", want.interval, interval);
                    fail_cnt++;
                end
                if (zero_width !== want.zero_width)
                begin
                    $error("zero_width: expected %0b, got %0b", want.zero_width, zero_width);
                    fail_cnt++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, saturated);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_write(int idx, logic [RADIUS_W-1:0] r, logic [VEL_W-1:0] p,
                              logic [VEL_W-1:0] s);
        tb_request_t req;
        req.func        = FUNC_WRITE;
        req.layer_index = idx[LAYER_AW-1:0];
        req.radius      = r;
        req.p_vel       = p;
        req.s_vel       = s;
        pending_requests.push_back(req);
        gen_radius[idx] = r;
    endtask

    // Fields a query does not use carry random noise.
    task automatic push_query(logic [FUNC_W-1:0] f, logic [RADIUS_W-1:0] r);
        tb_request_t req;
        req.func        = f;
        req.layer_index = LAYER_AW'($urandom);
        req.radius      = r;
        req.p_vel       = VEL_W'($urandom);
        req.s_vel       = VEL_W'($urandom);
        pending_requests.push_back(req);
    endtask

    function automatic int walk_speed(int v);
        int w;
        w = v + int'($urandom_range(0, 600000)) - 300000;
        if (w < 0)
            w = 0;
        if (w > VEL_MAX)
            w = VEL_MAX;
        return w;
    endfunction

    // Writes entries 0 .. n-1 so that no query can read an unwritten entry.
    // Most tables ascend, with a few equal neighbors; some descend or are scrambled.
    task automatic fill_table(int n);
        int shape;
        int i;
        int step_max;
        int vp;
        int vs;
        bit rough;
        logic [RADIUS_W-1:0] r;
        shape    = $urandom_range(0, 7);
        rough    = 1'($urandom_range(0, 1));
        step_max = (RADIUS_MAX - 2000) / n;
        r        = RADIUS_W'($urandom_range(0, 2000));
        vp       = $urandom_range(0, VEL_MAX);
        vs       = $urandom_range(0, VEL_MAX);
        for (i = 0; i < n; i++)
        begin
            if (shape == 7)
                r = RADIUS_W'($urandom);
            else if (i != 0 && $urandom_range(0, 7) != 0)
                r = r + RADIUS_W'($urandom_range(1, step_max));
            if (rough)
            begin
                vp = $urandom_range(0, VEL_MAX);
                vs = $urandom_range(0, VEL_MAX);
            end
            else
            begin
                vp = walk_speed(vp);
                vs = walk_speed(vs);
            end
            push_write((shape == 6) ? n - 1 - i : i, r, VEL_W'(vp), VEL_W'(vs));
        end
    endtask

    // Aims mostly inside an interval, sometimes at a knot or beyond either end.
    function automatic logic [RADIUS_W-1:0] pick_radius(int n);
        int sel;
        int k;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, n - 2);
        if (sel < 55)
            return RADIUS_W'($urandom_range(gen_radius[k], gen_radius[k + 1]));
        if (sel < 70)
            return gen_radius[$urandom_range(0, n - 1)];
        if (sel < 80)
            return RADIUS_W'($urandom_range(0, gen_radius[0]));
        if (sel < 90)
            return RADIUS_W'($urandom_range(gen_radius[n - 1], RADIUS_MAX));
        return RADIUS_W'($urandom);
    endfunction

    task automatic set_flow(int mode);
        case (mode)
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    // Waits until every request was taken and every result arrived, then lets
    // the longest query finish in case the last request produced no result.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || expected_speeds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_layer_count(logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int p;
        int k;
        int n;
        int sel;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset layer count of two.
        set_flow(0);
        push_write(0, 23'd1000, 24'd5000, 24'd3000);
        push_write(1, 23'd2000, 24'd9000, 24'd1000);
        push_query(FUNC_QUERY_P, 23'd0);
        push_query(FUNC_QUERY_P, 23'd1000);
        push_query(FUNC_QUERY_P, 23'd1500);
        push_query(FUNC_QUERY_S, 23'd1500);
        push_query(FUNC_QUERY_P, 23'd2000);
        push_query(FUNC_QUERY_P, 23'h7FFFFF);
        push_query(FUNC_QUERY_S, 23'h7FFFFF);
        push_query(FUNC_UNUSED, 23'd1234);
        // Both radii equal: the speed of entry 0 comes back with the flag set.
        push_write(1, 23'd1000, 24'd9000, 24'd1000);
        push_query(FUNC_QUERY_P, 23'd1000);
        push_query(FUNC_QUERY_S, 23'd5000);
        // Descending radii give a negative interval width.
        push_write(1, 23'd0, 24'hFFFFFF, 24'd0);
        push_query(FUNC_QUERY_P, 23'd500);
        push_query(FUNC_QUERY_S, 23'h7FFFFF);
        push_write(0, 23'd0, 24'd0, 24'hFFFFFF);
        push_write(1, 23'h7FFFFF, 24'hFFFFFF, 24'd0);
        push_query(FUNC_QUERY_P, 23'd0);
        push_query(FUNC_QUERY_P, 23'h400000);
        push_query(FUNC_QUERY_S, 23'h7FFFFF);
        push_query(FUNC_QUERY_P, 23'h7FFFFF);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                layer_settings[p] = $urandom_range(0, 127);
            set_layer_count(CFG_W'(layer_settings[p]));
            n = clamp_layers(layer_settings[p]);
            set_flow(p % 4);
            fill_table(n);
            for (k = 0; k < QUERY_ITEMS; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    push_write(int'($urandom_range(0, MAX_LAYERS - 1)), RADIUS_W'($urandom),
                               VEL_W'($urandom), VEL_W'($urandom));
                else if (sel < 10)
                    push_query(FUNC_UNUSED, RADIUS_W'($urandom));
                else
                    push_query($urandom_range(0, 1) ? FUNC_QUERY_P : FUNC_QUERY_S,
                               pick_radius(n));
            end
            wait_drained();
        end

        $display("Covered %0d accepted requests and %0d checked speeds", n_accepted, n_checked);
        $display("over %0d layer-count settings and four flow-control patterns.", PHASES + 1);
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
